[rtl/ptw_pkg.sv]
// Package for the x86 page table walker.
// Holds the input mode codes, result kind codes, FSM state type, command/status structs.
// No dependencies.
package ptw_pkg;

  localparam int DIR_ENTRIES_DEF = 2048;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_XLATE = 2'd1;
  localparam logic [1:0] MODE_REPLY = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  localparam logic [22:0] SMALL_PAGE = 23'h001000;
  localparam logic [22:0] PAGE_2M    = 23'h200000;
  localparam logic [22:0] PAGE_4M    = 23'h400000;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } ptw_state_t;

  typedef struct packed {
    logic dir_wr;
    logic dir_rd;
    logic fin_lookup;
    logic fin_reply;
  } ptw_cmd_t;

  typedef struct packed {
    logic walk;
  } ptw_sts_t;

endpackage

[rtl/ptw_ctrl.sv]
// Controller FSM for the page table walker: handshake, outstanding-read flag,
// config register and result strobe. Depends on ptw_pkg.
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  ptw_sts_t   sts,
  output logic       busy,
  output logic       pae,
  output ptw_cmd_t   cmd,
  output logic       out_valid
);

  ptw_state_t state_r, state_nxt;
  logic       awaiting_r, awaiting_nxt;
  logic       pae_r, pae_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign busy   = (state_r == ST_LOOKUP);
  assign accept = start && !busy;

  always_comb begin
    cmd = '0;
    unique case (in_mode)
      MODE_LOAD:  cmd.dir_wr    = accept;
      MODE_XLATE: cmd.dir_rd    = accept && !awaiting_r;
      MODE_REPLY: cmd.fin_reply = accept && awaiting_r;
      default:    cmd = '0;
    endcase
    cmd.fin_lookup = (state_r == ST_LOOKUP);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (cmd.dir_rd) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    awaiting_nxt = awaiting_r;
    if (cmd.fin_lookup) begin
      awaiting_nxt = sts.walk;
    end else if (cmd.fin_reply) begin
      awaiting_nxt = 1'b0;
    end
  end

  assign pae_nxt       = cfg_we ? cfg_wdata : pae_r;
  assign out_valid_nxt = cmd.fin_lookup || cmd.fin_reply;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b0;
      pae_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      pae_r       <= pae_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign pae       = pae_r;
  assign out_valid = out_valid_r;

  a_lookup_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |=> out_valid_r)
    else $error("lookup did not produce a result");

  a_xlate_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_XLATE && awaiting_r) |=> (state_r == ST_IDLE && !out_valid_r))
    else $error("translate taken while a table read is outstanding");

  a_await_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(awaiting_r) |-> $past(state_r == ST_LOOKUP))
    else $error("outstanding read flag set outside lookup");

  a_no_lookup_while_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |-> !awaiting_r)
    else $error("lookup running while a table read is outstanding");

endmodule

[rtl/ptw_datapath.sv]
// Datapath for the page table walker: directory RAM, pending address,
// entry decode and result registers. Depends on ptw_pkg.
module ptw_datapath
  import ptw_pkg::*;
#(
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF
) (
  input  logic        clk,
  input  ptw_cmd_t    cmd,
  input  logic        pae,
  input  logic [10:0] in_dir_index,
  input  logic [63:0] in_dir_word,
  input  logic [31:0] in_virt_addr,
  input  logic [63:0] in_entry_word,
  input  logic        in_read_ok,
  output ptw_sts_t    sts,
  output logic        out_kind,
  output logic [62:0] out_read_addr,
  output logic        out_found,
  output logic [62:0] out_phys_addr,
  output logic [22:0] out_span_len
);

  localparam int          AW    = $clog2(DIR_ENTRIES);
  localparam logic [11:0] DEPTH = 12'(DIR_ENTRIES);

  logic [63:0] dir_mem [DIR_ENTRIES];
  logic [63:0] rd_data_r;
  logic        in_range_r;
  logic [31:0] vaddr_r;

  logic [10:0] rd_idx;
  logic        wr_ok;
  logic [63:0] pde;
  logic        pde_hit;
  logic [21:0] lg_off;
  logic [62:0] lg_base;
  logic [22:0] lg_size;
  logic [11:0] tbl_off;
  logic [63:0] pte;
  logic        pte_hit;

  logic        kind_r, kind_nxt;
  logic [62:0] raddr_r, raddr_nxt;
  logic        found_r, found_nxt;
  logic [62:0] paddr_r, paddr_nxt;
  logic [22:0] span_r, span_nxt;

  assign rd_idx = pae ? in_virt_addr[31:21] : {1'b0, in_virt_addr[31:22]};
  assign wr_ok  = ({1'b0, in_dir_index} < DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.dir_wr && wr_ok) begin
      dir_mem[in_dir_index[AW-1:0]] <= in_dir_word;
    end
    if (cmd.dir_rd) begin
      rd_data_r  <= dir_mem[rd_idx[AW-1:0]];
      in_range_r <= ({1'b0, rd_idx} < DEPTH);
      vaddr_r    <= in_virt_addr;
    end
  end

  assign pde      = pae ? rd_data_r : {32'b0, rd_data_r[31:0]};
  assign pde_hit  = in_range_r && pde[BIT_PRESENT];
  assign sts.walk = pde_hit && !pde[BIT_LARGE];

  assign lg_size = pae ? PAGE_2M : PAGE_4M;
  assign lg_off  = pae ? {1'b0, vaddr_r[20:0]} : vaddr_r[21:0];
  assign lg_base = pae ? {pde[62:21], 21'b0} : {pde[62:22], 22'b0};
  assign tbl_off = pae ? {vaddr_r[20:12], 3'b0} : {vaddr_r[21:12], 2'b0};

  assign pte     = pae ? in_entry_word : {32'b0, in_entry_word[31:0]};
  assign pte_hit = in_read_ok && pte[BIT_PRESENT];

  always_comb begin
    kind_nxt  = KIND_DONE;
    raddr_nxt = '0;
    found_nxt = 1'b0;
    paddr_nxt = '0;
    span_nxt  = '0;
    if (cmd.fin_lookup) begin
      if (sts.walk) begin
        kind_nxt  = KIND_READ;
        raddr_nxt = {pde[62:12], tbl_off};
      end else if (pde_hit) begin
        found_nxt = 1'b1;
        paddr_nxt = lg_base | {41'b0, lg_off};
        span_nxt  = lg_size - {1'b0, lg_off};
      end
    end else if (pte_hit) begin
      found_nxt = 1'b1;
      paddr_nxt = {pte[62:12], vaddr_r[11:0]};
      span_nxt  = SMALL_PAGE - {11'b0, vaddr_r[11:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_lookup || cmd.fin_reply) begin
      kind_r  <= kind_nxt;
      raddr_r <= raddr_nxt;
      found_r <= found_nxt;
      paddr_r <= paddr_nxt;
      span_r  <= span_nxt;
    end
  end

  assign out_kind      = kind_r;
  assign out_read_addr = raddr_r;
  assign out_found     = found_r;
  assign out_phys_addr = paddr_r;
  assign out_span_len  = span_r;

endmodule

[rtl/x86_page_table_walker.sv]
// x86 two-level page table walker with PAE: top level.
// Joins ptw_ctrl (FSM) and ptw_datapath (directory RAM, decode). Depends on ptw_pkg.
//
// Usage: drive an item with start while busy is low. Directory loads (mode 0) and
// table-entry replies (mode 2) do not raise busy; a reply's result appears on
// out_* with out_valid the cycle after the transfer. A translate request (mode 1)
// passes through the registered read of the on-chip directory RAM: busy is high for
// one cycle and the result (a table-entry read request or a finished translation)
// strobes the cycle after that. Results are shown for exactly one cycle with
// out_valid and cannot be held off; the next item may be sent while a result is shown.
// Only one table-entry read is outstanding; translates sent meanwhile are dropped.
// Write cfg_wdata (PAE enable) with cfg_we only while no item is in flight.
module x86_page_table_walker
  import ptw_pkg::*;
#(
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [10:0] in_dir_index,
  input  logic [63:0] in_dir_word,
  input  logic [31:0] in_virt_addr,
  input  logic [63:0] in_entry_word,
  input  logic        in_read_ok,
  output logic        out_valid,
  output logic        out_kind,
  output logic [62:0] out_read_addr,
  output logic        out_found,
  output logic [62:0] out_phys_addr,
  output logic [22:0] out_span_len,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;
  logic     pae;

  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .busy      (busy),
    .pae       (pae),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  ptw_datapath #(
    .DIR_ENTRIES (DIR_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .pae           (pae),
    .in_dir_index  (in_dir_index),
    .in_dir_word   (in_dir_word),
    .in_virt_addr  (in_virt_addr),
    .in_entry_word (in_entry_word),
    .in_read_ok    (in_read_ok),
    .sts           (sts),
    .out_kind      (out_kind),
    .out_read_addr (out_read_addr),
    .out_found     (out_found),
    .out_phys_addr (out_phys_addr),
    .out_span_len  (out_span_len)
  );

endmodule
